// File: rtl/twsc_pkg.sv
// Shared types, constants and codes for the trie word store.
`timescale 1ns / 1ps
package twsc_pkg;

	// Default sizing of the node store
	localparam int MAX_NODES_DEF     = 1024;
	localparam int ALPHABET_SIZE_DEF = 26;

	// Fixed field widths
	localparam int REQ_W    = 2;
	localparam int LETTER_W = 5;
	localparam int STATUS_W = 2;
	localparam int USED_W   = 11;

	// Depth of the queue between front and back, and of the result queue
	localparam int CMD_DEPTH = 4;
	localparam int RES_DEPTH = 2;

	typedef logic [REQ_W-1:0]    op_t;
	typedef logic [STATUS_W-1:0] status_t;

	// Request codes
	localparam op_t OP_INSERT  = 2'd0;
	localparam op_t OP_SEARCH  = 2'd1;
	localparam op_t OP_DELETE  = 2'd2;
	localparam op_t OP_UNKNOWN = 2'd3;

	// Status codes
	localparam status_t ST_OK        = 2'd0;
	localparam status_t ST_NOT_FOUND = 2'd1;
	localparam status_t ST_FULL      = 2'd2;

	// Input transaction
	typedef struct packed {
		op_t                 req_type;
		logic [LETTER_W-1:0] letter;
		logic                word_end;
	} in_item_t;

	// Result transaction
	typedef struct packed {
		status_t           status;
		logic [USED_W-1:0] nodes_used;
	} out_item_t;

	// Classified command handed from front to back
	typedef struct packed {
		logic                first;     // opens a word
		op_t                 op;        // normalized operation, valid when first
		logic                word_end;
		logic                bad;       // letter outside the alphabet
		logic [LETTER_W-1:0] letter;
	} cmd_t;

endpackage

// File: rtl/twsc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module twsc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/twsc_fifo.sv
// Small register-based queue used between front and back and for results.
`timescale 1ns / 1ps
module twsc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = slot_q[rd_ptr_q];

	// Storage, no reset needed
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

	// Pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/twsc_front.sv
// Front end: accepts input transactions, tracks word boundaries, classifies letters.
`timescale 1ns / 1ps
module twsc_front #(
	parameter int ALPHABET_SIZE = twsc_pkg::ALPHABET_SIZE_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  twsc_pkg::in_item_t item,
	input  logic               stall,
	output logic               full,
	output logic               cmd_push,
	output twsc_pkg::cmd_t     cmd
);

	import twsc_pkg::*;

	logic inside_word_q;

	assign full     = stall;
	assign cmd_push = push && !stall;

	// Classify the incoming item
	always_comb begin
		cmd.first    = !inside_word_q;
		cmd.op       = (item.req_type == OP_UNKNOWN) ? OP_SEARCH : item.req_type;
		cmd.word_end = item.word_end;
		cmd.bad      = (32'(item.letter) >= ALPHABET_SIZE);
		cmd.letter   = item.letter;
	end

	// Word boundary tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_word_q <= 1'b0;
		end else if (cmd_push) begin
			inside_word_q <= !item.word_end;
		end
	end

endmodule

// File: rtl/twsc_back.sv
// Back end: walks the trie in the node store and produces one result per word.
`timescale 1ns / 1ps
module twsc_back #(
	parameter int MAX_NODES     = twsc_pkg::MAX_NODES_DEF,
	parameter int ALPHABET_SIZE = twsc_pkg::ALPHABET_SIZE_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	input  twsc_pkg::cmd_t      cmd,
	output logic                cmd_pop,
	input  logic                res_full,
	output logic                res_push,
	output twsc_pkg::out_item_t res_data,
	output logic                clearing
);

	import twsc_pkg::*;

	localparam int NODE_W  = $clog2(MAX_NODES);
	localparam int NF_W    = $clog2(MAX_NODES + 1);
	localparam int DEPTH   = MAX_NODES * ALPHABET_SIZE;
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int EXT_W   = (NF_W > USED_W) ? NF_W : USED_W;

	typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_LOOK, S_MARK} state_t;

	state_t            state_q, state_d;
	logic [ADDR_W-1:0] clr_q;
	logic [NODE_W-1:0] cur_q, cur_d;
	logic              broken_q, broken_d;
	logic              ovf_q, ovf_d;
	op_t               op_q, op_d;
	logic [NF_W-1:0]   next_free_q, next_free_d;
	logic [ADDR_W-1:0] slot_q, slot_d;

	// Effective word state, fresh when the command opens a word
	op_t               eff_op;
	logic [NODE_W-1:0] eff_cur;
	logic              eff_broken;
	logic              eff_ovf;
	logic [ADDR_W-1:0] slot_calc;

	// Memory ports
	logic              child_we;
	logic [ADDR_W-1:0] child_waddr;
	logic [NODE_W-1:0] child_wdata;
	logic [NODE_W-1:0] child_rdata;
	logic              mark_we;
	logic [NODE_W-1:0] mark_waddr;
	logic              mark_wdata;
	logic              mark_rdata;
	logic [EXT_W-1:0]  nf_ext;

	assign eff_op     = cmd.first ? cmd.op : op_q;
	assign eff_cur    = cmd.first ? '0 : cur_q;
	assign eff_broken = cmd.first ? 1'b0 : broken_q;
	assign eff_ovf    = cmd.first ? 1'b0 : ovf_q;
	assign slot_calc  = ADDR_W'(eff_cur) * ADDR_W'(ALPHABET_SIZE) + ADDR_W'(cmd.letter);
	assign nf_ext     = EXT_W'(next_free_q);
	assign clearing   = (state_q == S_CLEAR);

	twsc_ram #(.WIDTH(NODE_W), .DEPTH(DEPTH)) u_child_ram (
		.clk   (clk),
		.we    (child_we),
		.waddr (child_waddr),
		.wdata (child_wdata),
		.raddr (slot_calc),
		.rdata (child_rdata)
	);

	twsc_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_mark_ram (
		.clk   (clk),
		.we    (mark_we),
		.waddr (mark_waddr),
		.wdata (mark_wdata),
		.raddr (eff_cur),
		.rdata (mark_rdata)
	);

	// Sequencer next state and memory control
	always_comb begin
		state_d     = state_q;
		cur_d       = cur_q;
		broken_d    = broken_q;
		ovf_d       = ovf_q;
		op_d        = op_q;
		next_free_d = next_free_q;
		slot_d      = slot_q;
		cmd_pop     = 1'b0;
		res_push    = 1'b0;
		res_data.status     = ST_OK;
		res_data.nodes_used = nf_ext[USED_W-1:0];
		child_we    = 1'b0;
		child_waddr = slot_q;
		child_wdata = next_free_q[NODE_W-1:0];
		mark_we     = 1'b0;
		mark_waddr  = eff_cur;
		mark_wdata  = 1'b0;

		unique case (state_q)
			S_CLEAR: begin
				// Null every child slot; marks share the first rows of the sweep
				child_we    = 1'b1;
				child_waddr = clr_q;
				child_wdata = '0;
				mark_we     = (32'(clr_q) < MAX_NODES);
				mark_waddr  = clr_q[NODE_W-1:0];
				mark_wdata  = 1'b0;
				if (clr_q == ADDR_W'(DEPTH - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (cmd_valid && !res_full) begin
					cmd_pop  = 1'b1;
					op_d     = eff_op;
					cur_d    = eff_cur;
					broken_d = eff_broken;
					ovf_d    = eff_ovf;
					if (!cmd.word_end) begin
						// Letter: start the child lookup unless the walk has stopped; a letter outside the alphabet breaks the walk
						if (!eff_broken && !eff_ovf) begin
							if (cmd.bad) begin
								broken_d = 1'b1;
							end else begin
								slot_d  = slot_calc;
								state_d = S_LOOK;
							end
						end
					end else begin
						// End of word
						priority if (eff_op == OP_SEARCH) begin
							if (eff_broken) begin
								res_push        = 1'b1;
								res_data.status = ST_NOT_FOUND;
							end else begin
								state_d = S_MARK;
							end
						end else if (eff_op == OP_INSERT) begin
							res_push = 1'b1;
							if (eff_ovf) begin
								res_data.status = ST_FULL;
							end else if (eff_broken) begin
								res_data.status = ST_NOT_FOUND;
							end else begin
								mark_we         = 1'b1;
								mark_wdata      = 1'b1;
								res_data.status = ST_OK;
							end
						end else begin
							res_push = 1'b1;
							if (eff_broken) begin
								res_data.status = ST_NOT_FOUND;
							end else begin
								mark_we         = 1'b1;
								mark_wdata      = 1'b0;
								res_data.status = ST_OK;
							end
						end
					end
				end
			end
			S_LOOK: begin
				// Resolve the child read: follow, break, flag overflow, or allocate
				state_d = S_IDLE;
				priority if (child_rdata != '0) begin
					cur_d = child_rdata;
				end else if (op_q != OP_INSERT) begin
					broken_d = 1'b1;
				end else if (next_free_q == NF_W'(MAX_NODES)) begin
					ovf_d = 1'b1;
				end else begin
					child_we    = 1'b1;
					child_waddr = slot_q;
					child_wdata = next_free_q[NODE_W-1:0];
					cur_d       = next_free_q[NODE_W-1:0];
					next_free_d = next_free_q + 1'b1;
				end
			end
			S_MARK: begin
				// Search result from the end node's mark
				state_d         = S_IDLE;
				res_push        = 1'b1;
				res_data.status = mark_rdata ? ST_OK : ST_NOT_FOUND;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Sequencer state and word registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			cur_q       <= '0;
			broken_q    <= 1'b0;
			ovf_q       <= 1'b0;
			op_q        <= OP_INSERT;
			next_free_q <= NF_W'(1);
			slot_q      <= '0;
		end else begin
			state_q     <= state_d;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			cur_q       <= cur_d;
			broken_q    <= broken_d;
			ovf_q       <= ovf_d;
			op_q        <= op_d;
			next_free_q <= next_free_d;
			slot_q      <= slot_d;
		end
	end

endmodule

// File: rtl/trie_word_store_core.sv
// Top level of the trie word store: front end, command queue, back end, result queue.
`timescale 1ns / 1ps
// Stores lower-case words in a trie of up to MAX_NODES nodes, each with
// ALPHABET_SIZE child slots, and runs insert, search and delete on words fed
// one letter per transaction and closed by an end transaction, which returns
// one result. After reset every child slot and mark of the node store is
// swept to null with full held high. Each accepted transaction is registered
// in the command queue before the back end sees it. In the back end a letter
// first reads the child slot of the current node from the synchronous child
// memory and then follows it, allocates a node or stops the walk. A letter
// that arrives after the walk has stopped, or that lies outside the alphabet,
// skips the child read. An end transaction gives its result straight from the
// idle state, except a search whose path holds, which first reads the end
// node's mark. A four-entry command queue lets input transactions pile up
// while the back end walks, and a two-entry result queue holds results until
// they are popped.
module trie_word_store_core #(
	parameter int MAX_NODES     = twsc_pkg::MAX_NODES_DEF,
	parameter int ALPHABET_SIZE = twsc_pkg::ALPHABET_SIZE_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  twsc_pkg::in_item_t  item,
	output logic                empty,
	input  logic                pop,
	output twsc_pkg::out_item_t result
);

	import twsc_pkg::*;

	localparam int CMD_W = $bits(cmd_t);
	localparam int RES_W = $bits(out_item_t);

	logic       clearing;
	logic       cmd_full;
	logic       cmd_empty;
	logic       cmd_push;
	logic       cmd_pop;
	cmd_t       cmd_in;
	cmd_t       cmd_out;
	logic       res_full;
	logic       res_push;
	out_item_t  res_data;

	twsc_front #(.ALPHABET_SIZE(ALPHABET_SIZE)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.item     (item),
		.stall    (cmd_full || clearing),
		.full     (full),
		.cmd_push (cmd_push),
		.cmd      (cmd_in)
	);

	twsc_fifo #(.WIDTH(CMD_W), .DEPTH(CMD_DEPTH)) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd_in),
		.pop    (cmd_pop),
		.rdata  (cmd_out),
		.full   (cmd_full),
		.empty  (cmd_empty)
	);

	twsc_back #(.MAX_NODES(MAX_NODES), .ALPHABET_SIZE(ALPHABET_SIZE)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (!cmd_empty),
		.cmd       (cmd_out),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res_data  (res_data),
		.clearing  (clearing)
	);

	twsc_fifo #(.WIDTH(RES_W), .DEPTH(RES_DEPTH)) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_data),
		.pop    (pop),
		.rdata  (result),
		.full   (res_full),
		.empty  (empty)
	);

endmodule
